[design/apqm_pkg.sv]
package apqm_pkg;

    // field widths
    localparam int ANGLE_W   = 16;
    localparam int ERR_W     = ANGLE_W + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int INTEG_W   = 27;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 48;
    localparam int BASE_W    = 12;
    localparam int MOTOR_W   = 11;
    localparam int ARM_W     = 8;
    localparam int REG_IDX_W = 2;

    // shared datapath widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int TERM_W  = 48;
    localparam int ACC_W   = 50;

    localparam int NUM_AXES   = 3;
    localparam int NUM_MOTORS = 4;

    // scaling: integral kept as sum of Q.7 errors, terms scaled by 100 * 2^15
    localparam int INTEG_LIMIT = 200000 * (2 ** 7);
    localparam int P_SCALE     = 100;
    localparam int D_SCALE     = 10000;
    localparam int MIX_SCALE   = 100 * (2 ** 15);
    localparam int MOTOR_MIN   = 1000;
    localparam int MOTOR_MAX   = 2000;
    localparam int ARM_MIN     = 8;

    // mix scale is 25 * 2^17: between the clamps, (sum - 1000 * scale) >> 17
    // stays under 25000, where times ceil(2^20 / 25) >> 20 is an exact divide by 25
    localparam int QUOT_SHIFT  = 17;
    localparam int QUOT_W      = 15;
    localparam int RECIP_25    = 41944;
    localparam int RECIP_SHIFT = 20;
    localparam int US_OFS_W    = 10;

    localparam logic signed [ACC_W-1:0] MIX_AT_MIN =
        ACC_W'(longint'(MIX_SCALE) * MOTOR_MIN);
    localparam logic signed [ACC_W-1:0] MIX_AT_MAX =
        ACC_W'(longint'(MIX_SCALE) * MOTOR_MAX);

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_PITCH_GAINS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROLL_GAINS  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_YAW_GAINS   = 2'd2;

    typedef enum logic [1:0] {AX_PITCH, AX_ROLL, AX_YAW} axis_t;
    typedef enum logic [1:0] {MT_FRONT, MT_RIGHT, MT_BACK, MT_LEFT} motor_t;
    typedef enum logic [2:0] {
        MA_ERR, MA_PROD, MA_INTEG, MA_DIFF, MA_MSCALE, MA_QUOT
    } mul_a_t;
    typedef enum logic [2:0] {
        MB_C100, MB_C10000, MB_KP, MB_KI, MB_KD, MB_BASE, MB_RECIP
    } mul_b_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_CLR, ACC_LOAD, ACC_ADD} acc_op_t;
    typedef enum logic [1:0] {OPND_PROD, OPND_TERM, OPND_MIN} opnd_t;

    typedef enum logic [4:0] {
        S_IDLE, S_ERR, S_P0, S_P1, S_I, S_D0, S_D1, S_ACC, S_TERM,
        S_BASE, S_LOAD, S_MIX_A, S_MIX_B, S_CHECK, S_SCALE, S_MOTOR, S_OUT
    } state_t;

    typedef struct packed {
        logic    busy;
        logic    capture;
        logic    err_upd;
        axis_t   axis;
        logic    mul_en;
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        acc_op_t acc_op;
        opnd_t   opnd;
        axis_t   term_axis;
        logic    term_neg;
        logic    term_wr;
        motor_t  motor;
        logic    range_chk;
        logic    motor_wr;
        logic    out_load;
    } ctl_t;

    typedef struct packed {
        axis_t axis;
        logic  neg;
    } mix_sel_t;

    // plus-frame mixer: which axis term enters each motor, and with which sign
    function automatic mix_sel_t mix_sel(motor_t m, logic slot);
        mix_sel_t r;
        r.axis = AX_YAW;
        r.neg  = 1'b0;
        case (m)
            MT_FRONT:
            begin
                r.axis = slot ? AX_YAW : AX_PITCH;
                r.neg  = slot;
            end
            MT_RIGHT:
            begin
                r.axis = slot ? AX_YAW : AX_ROLL;
                r.neg  = !slot;
            end
            MT_BACK:
            begin
                r.axis = slot ? AX_YAW : AX_PITCH;
                r.neg  = 1'b1;
            end
            MT_LEFT:
            begin
                r.axis = slot ? AX_YAW : AX_ROLL;
                r.neg  = 1'b0;
            end
            default:
            begin
                r.axis = AX_YAW;
                r.neg  = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

[design/attitude_pid_quad_mixer.sv]
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   angles, targets, base throttles, arm_level
// out      output     out_valid/out_stall motor_front/right/back/left, write_pwm
// cfg      input      cfg_we              cfg_index, cfg_data (no stall)
//
// a word goes through the three axes on the shared 32x16 multiplier and
// 50-bit adder, then through the four motors for the mix, the range check
// and a reciprocal multiply on that same multiplier
// in_stall stays high from acceptance until the result is loaded, so the
// next word is not taken before then; a held result in the output register
// (out_stall high) delays the load further
// reset clears gains, integrals, last errors, sequencer and out_valid
module attitude_pid_quad_mixer
    import apqm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic        [REG_IDX_W-1:0] cfg_index,
    input  logic        [CFG_W-1:0]     cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [ANGLE_W-1:0]   pitch_angle,
    input  logic signed [ANGLE_W-1:0]   roll_angle,
    input  logic signed [ANGLE_W-1:0]   yaw_angle,
    input  logic signed [ANGLE_W-1:0]   pitch_target,
    input  logic signed [ANGLE_W-1:0]   roll_target,
    input  logic signed [ANGLE_W-1:0]   yaw_target,
    input  logic        [BASE_W-1:0]    base_front,
    input  logic        [BASE_W-1:0]    base_right,
    input  logic        [BASE_W-1:0]    base_back,
    input  logic        [BASE_W-1:0]    base_left,
    input  logic        [ARM_W-1:0]     arm_level,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic        [MOTOR_W-1:0]   motor_front,
    output logic        [MOTOR_W-1:0]   motor_right,
    output logic        [MOTOR_W-1:0]   motor_back,
    output logic        [MOTOR_W-1:0]   motor_left,
    output logic                        write_pwm
);

    ctl_t               ctl;
    logic               in_fire;
    logic               out_free;
    logic [MOTOR_W-1:0] res_front, res_right, res_back, res_left;
    logic               res_armed;
    logic               out_valid_reg;
    logic [MOTOR_W-1:0] front_reg, right_reg, back_reg, left_reg;
    logic               pwm_reg;

    assign in_stall = ctl.busy;
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    apqm_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .ctl      (ctl)
    );

    apqm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pitch_angle  (pitch_angle),
        .roll_angle   (roll_angle),
        .yaw_angle    (yaw_angle),
        .pitch_target (pitch_target),
        .roll_target  (roll_target),
        .yaw_target   (yaw_target),
        .base_front   (base_front),
        .base_right   (base_right),
        .base_back    (base_back),
        .base_left    (base_left),
        .arm_level    (arm_level),
        .res_front    (res_front),
        .res_right    (res_right),
        .res_back     (res_back),
        .res_left     (res_left),
        .res_armed    (res_armed)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            front_reg <= res_front;
            right_reg <= res_right;
            back_reg  <= res_back;
            left_reg  <= res_left;
            pwm_reg   <= res_armed;
        end
    end

    assign out_valid   = out_valid_reg;
    assign motor_front = front_reg;
    assign motor_right = right_reg;
    assign motor_back  = back_reg;
    assign motor_left  = left_reg;
    assign write_pwm   = pwm_reg;

endmodule

[design/apqm_mul.sv]
module apqm_mul
    import apqm_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic        [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W:0]   full;
    logic signed [PROD_W-1:0] prod_reg;

    // b is unsigned, so it gets a zero sign bit
    assign full = a * $signed({1'b0, b});
    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full[PROD_W-1:0];
        end
    end

endmodule

[design/apqm_dp.sv]
module apqm_dp
    import apqm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctl_t                        ctl,
    input  logic                        cfg_we,
    input  logic        [REG_IDX_W-1:0] cfg_index,
    input  logic        [CFG_W-1:0]     cfg_data,
    input  logic signed [ANGLE_W-1:0]   pitch_angle,
    input  logic signed [ANGLE_W-1:0]   roll_angle,
    input  logic signed [ANGLE_W-1:0]   yaw_angle,
    input  logic signed [ANGLE_W-1:0]   pitch_target,
    input  logic signed [ANGLE_W-1:0]   roll_target,
    input  logic signed [ANGLE_W-1:0]   yaw_target,
    input  logic        [BASE_W-1:0]    base_front,
    input  logic        [BASE_W-1:0]    base_right,
    input  logic        [BASE_W-1:0]    base_back,
    input  logic        [BASE_W-1:0]    base_left,
    input  logic        [ARM_W-1:0]     arm_level,
    output logic        [MOTOR_W-1:0]   res_front,
    output logic        [MOTOR_W-1:0]   res_right,
    output logic        [MOTOR_W-1:0]   res_back,
    output logic        [MOTOR_W-1:0]   res_left,
    output logic                        res_armed
);

    localparam logic signed [INTEG_W:0] INTEG_HI = (INTEG_W + 1)'(INTEG_LIMIT);
    localparam logic signed [INTEG_W:0] INTEG_LO = -INTEG_HI;

    logic signed [ANGLE_W-1:0] angle_reg  [NUM_AXES];
    logic signed [ANGLE_W-1:0] target_reg [NUM_AXES];
    logic        [BASE_W-1:0]  base_reg   [NUM_MOTORS];
    logic                      armed_reg;
    logic        [CFG_W-1:0]   gains_reg  [NUM_AXES];
    logic signed [INTEG_W-1:0] integ_reg  [NUM_AXES];
    logic signed [ERR_W-1:0]   last_reg   [NUM_AXES];
    logic signed [TERM_W-1:0]  term_reg   [NUM_AXES];
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      lo_reg;
    logic                      hi_reg;
    logic        [MOTOR_W-1:0] mres_reg   [NUM_MOTORS];

    logic signed [ERR_W-1:0]   err_cur;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W:0]   integ_clamp;
    logic signed [DIFF_W-1:0]  diff_cur;
    logic        [CFG_W-1:0]   gain_cur;
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   term_sel;
    logic signed [ACC_W-1:0]   opnd;
    logic signed [ACC_W-1:0]   sum;
    logic        [MOTOR_W-1:0] mot_val;

    // error, integral update and error change for the current axis
    always_comb
    begin
        err_cur   = ERR_W'(target_reg[ctl.axis]) - ERR_W'(angle_reg[ctl.axis]);
        integ_sum = (INTEG_W + 1)'(integ_reg[ctl.axis]) + (INTEG_W + 1)'(err_cur);
        if (integ_sum > INTEG_HI)
        begin
            integ_clamp = INTEG_HI;
        end
        else if (integ_sum < INTEG_LO)
        begin
            integ_clamp = INTEG_LO;
        end
        else
        begin
            integ_clamp = integ_sum;
        end
        diff_cur = DIFF_W'(err_cur) - DIFF_W'(last_reg[ctl.axis]);
        gain_cur = gains_reg[ctl.axis];
    end

    // multiplier operand selection
    always_comb
    begin
        case (ctl.mul_a)
            MA_ERR:    mul_a = MUL_A_W'(err_reg);
            MA_PROD:   mul_a = prod[MUL_A_W-1:0];
            MA_INTEG:  mul_a = MUL_A_W'(integ_reg[ctl.axis]);
            MA_DIFF:   mul_a = MUL_A_W'(diff_reg);
            MA_MSCALE: mul_a = MUL_A_W'(MIX_SCALE);
            MA_QUOT:   mul_a = MUL_A_W'(acc_reg[QUOT_SHIFT+QUOT_W-1:QUOT_SHIFT]);
            default:   mul_a = '0;
        endcase
        case (ctl.mul_b)
            MB_C100:   mul_b = MUL_B_W'(P_SCALE);
            MB_C10000: mul_b = MUL_B_W'(D_SCALE);
            MB_KP:     mul_b = gain_cur[GAIN_W-1:0];
            MB_KI:     mul_b = gain_cur[2*GAIN_W-1:GAIN_W];
            MB_KD:     mul_b = gain_cur[3*GAIN_W-1:2*GAIN_W];
            MB_BASE:   mul_b = MUL_B_W'(base_reg[ctl.motor]);
            MB_RECIP:  mul_b = MUL_B_W'(RECIP_25);
            default:   mul_b = '0;
        endcase
    end

    apqm_mul u_mul (
        .clk  (clk),
        .en   (ctl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // shared adder: accumulate products and terms, then take off the low clamp point
    always_comb
    begin
        term_sel = ACC_W'(term_reg[ctl.term_axis]);
        case (ctl.opnd)
            OPND_PROD: opnd = ACC_W'(prod);
            OPND_TERM: opnd = ctl.term_neg ? -term_sel : term_sel;
            OPND_MIN:  opnd = -MIX_AT_MIN;
            default:   opnd = '0;
        endcase
        sum = acc_reg + opnd;
    end

    // between the clamps the reciprocal product gives whole microseconds above 1000
    always_comb
    begin
        if (lo_reg)
        begin
            mot_val = MOTOR_W'(MOTOR_MIN);
        end
        else if (hi_reg)
        begin
            mot_val = MOTOR_W'(MOTOR_MAX);
        end
        else
        begin
            mot_val = MOTOR_W'(MOTOR_MIN) +
                      MOTOR_W'(prod[RECIP_SHIFT+US_OFS_W-1:RECIP_SHIFT]);
        end
    end

    // gains and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                gains_reg[i] <= '0;
                integ_reg[i] <= '0;
                last_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PITCH_GAINS: gains_reg[AX_PITCH] <= cfg_data;
                    REG_ROLL_GAINS:  gains_reg[AX_ROLL]  <= cfg_data;
                    REG_YAW_GAINS:   gains_reg[AX_YAW]   <= cfg_data;
                    default:         ;
                endcase
            end
            if (ctl.err_upd)
            begin
                integ_reg[ctl.axis] <= integ_clamp[INTEG_W-1:0];
                last_reg[ctl.axis]  <= err_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            angle_reg[AX_PITCH]  <= pitch_angle;
            angle_reg[AX_ROLL]   <= roll_angle;
            angle_reg[AX_YAW]    <= yaw_angle;
            target_reg[AX_PITCH] <= pitch_target;
            target_reg[AX_ROLL]  <= roll_target;
            target_reg[AX_YAW]   <= yaw_target;
            base_reg[MT_FRONT]   <= base_front;
            base_reg[MT_RIGHT]   <= base_right;
            base_reg[MT_BACK]    <= base_back;
            base_reg[MT_LEFT]    <= base_left;
            armed_reg            <= arm_level > ARM_W'(ARM_MIN);
        end
        if (ctl.err_upd)
        begin
            err_reg  <= err_cur;
            diff_reg <= diff_cur;
        end
        case (ctl.acc_op)
            ACC_CLR:  acc_reg <= '0;
            ACC_LOAD: acc_reg <= ACC_W'(prod);
            ACC_ADD:  acc_reg <= sum;
            default:  ;
        endcase
        if (ctl.term_wr)
        begin
            term_reg[ctl.axis] <= acc_reg[TERM_W-1:0];
        end
        // clamp flags come from the full mix sum, before the offset is taken off
        if (ctl.range_chk)
        begin
            lo_reg <= acc_reg < MIX_AT_MIN;
            hi_reg <= acc_reg >= MIX_AT_MAX;
        end
        if (ctl.motor_wr)
        begin
            mres_reg[ctl.motor] <= mot_val;
        end
    end

    assign res_front = mres_reg[MT_FRONT];
    assign res_right = mres_reg[MT_RIGHT];
    assign res_back  = mres_reg[MT_BACK];
    assign res_left  = mres_reg[MT_LEFT];
    assign res_armed = armed_reg;

endmodule

[design/apqm_seq.sv]
module apqm_seq
    import apqm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic out_free,
    output ctl_t ctl
);

    state_t   state_reg, state_next;
    axis_t    axis_reg, axis_next;
    motor_t   motor_reg, motor_next;
    mix_sel_t sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= AX_PITCH;
            motor_reg <= MT_FRONT;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            motor_reg <= motor_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        motor_next = motor_reg;
        sel        = mix_sel(motor_reg, state_reg == S_MIX_B);

        ctl.busy      = state_reg != S_IDLE;
        ctl.capture   = 1'b0;
        ctl.err_upd   = 1'b0;
        ctl.axis      = axis_reg;
        ctl.mul_en    = 1'b0;
        ctl.mul_a     = MA_ERR;
        ctl.mul_b     = MB_C100;
        ctl.acc_op    = ACC_HOLD;
        ctl.opnd      = OPND_PROD;
        ctl.term_axis = sel.axis;
        ctl.term_neg  = sel.neg;
        ctl.term_wr   = 1'b0;
        ctl.motor     = motor_reg;
        ctl.range_chk = 1'b0;
        ctl.motor_wr  = 1'b0;
        ctl.out_load  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                ctl.capture = in_fire;
                if (in_fire)
                begin
                    axis_next  = AX_PITCH;
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                ctl.err_upd = 1'b1;
                ctl.acc_op  = ACC_CLR;
                state_next  = S_P0;
            end
            S_P0:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_ERR;
                ctl.mul_b  = MB_C100;
                state_next = S_P1;
            end
            S_P1:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_PROD;
                ctl.mul_b  = MB_KP;
                state_next = S_I;
            end
            S_I:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_INTEG;
                ctl.mul_b  = MB_KI;
                ctl.acc_op = ACC_ADD;
                state_next = S_D0;
            end
            S_D0:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_DIFF;
                ctl.mul_b  = MB_C10000;
                ctl.acc_op = ACC_ADD;
                state_next = S_D1;
            end
            S_D1:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_PROD;
                ctl.mul_b  = MB_KD;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                ctl.acc_op = ACC_ADD;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                ctl.term_wr = 1'b1;
                case (axis_reg)
                    AX_PITCH:
                    begin
                        axis_next  = AX_ROLL;
                        state_next = S_ERR;
                    end
                    AX_ROLL:
                    begin
                        axis_next  = AX_YAW;
                        state_next = S_ERR;
                    end
                    default:
                    begin
                        motor_next = MT_FRONT;
                        state_next = S_BASE;
                    end
                endcase
            end
            S_BASE:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_MSCALE;
                ctl.mul_b  = MB_BASE;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                ctl.acc_op = ACC_LOAD;
                state_next = S_MIX_A;
            end
            S_MIX_A:
            begin
                ctl.acc_op = ACC_ADD;
                ctl.opnd   = OPND_TERM;
                state_next = S_MIX_B;
            end
            S_MIX_B:
            begin
                ctl.acc_op = ACC_ADD;
                ctl.opnd   = OPND_TERM;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ctl.range_chk = 1'b1;
                ctl.acc_op    = ACC_ADD;
                ctl.opnd      = OPND_MIN;
                state_next    = S_SCALE;
            end
            S_SCALE:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MA_QUOT;
                ctl.mul_b  = MB_RECIP;
                state_next = S_MOTOR;
            end
            S_MOTOR:
            begin
                ctl.motor_wr = 1'b1;
                case (motor_reg)
                    MT_FRONT:
                    begin
                        motor_next = MT_RIGHT;
                        state_next = S_BASE;
                    end
                    MT_RIGHT:
                    begin
                        motor_next = MT_BACK;
                        state_next = S_BASE;
                    end
                    MT_BACK:
                    begin
                        motor_next = MT_LEFT;
                        state_next = S_BASE;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_OUT:
            begin
                // hold here until the previous result word is taken
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/apqm_chk.sv]
module apqm_chk
    import apqm_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic        [MOTOR_W-1:0] motor_front,
    input logic        [MOTOR_W-1:0] motor_right,
    input logic        [MOTOR_W-1:0] motor_back,
    input logic        [MOTOR_W-1:0] motor_left,
    input logic                      write_pwm
);

    // an accepted word keeps the input side stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a word");

    // a new result shows up exactly when the block goes back to taking words
    a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $fell(in_stall))
        else $error("result word appeared outside the end of an update");

    a_motor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            motor_front >= MOTOR_W'(MOTOR_MIN) && motor_front <= MOTOR_W'(MOTOR_MAX) &&
            motor_right >= MOTOR_W'(MOTOR_MIN) && motor_right <= MOTOR_W'(MOTOR_MAX) &&
            motor_back  >= MOTOR_W'(MOTOR_MIN) && motor_back  <= MOTOR_W'(MOTOR_MAX) &&
            motor_left  >= MOTOR_W'(MOTOR_MIN) && motor_left  <= MOTOR_W'(MOTOR_MAX))
        else $error("motor value outside the saturation range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(motor_front) &&
            $stable(motor_right) && $stable(motor_back) && $stable(motor_left) &&
            $stable(write_pwm))
        else $error("stalled result word changed");

endmodule

bind attitude_pid_quad_mixer apqm_chk u_apqm_chk (.*);
